@@ hw/rtl/lbm_pkg.sv @@
package lbm_pkg;

	// defaults for the top level parameters
	localparam int MAX_NEEDLE_DEF    = 8;
	localparam int CONTEXT_BYTES_DEF = 8;
	localparam int OFFSET_WIDTH_DEF  = 32;

	// fixed field widths
	localparam int NEEDLE_W     = 64;
	localparam int LENGTH_W     = 4;
	localparam int OFFSET_OUT_W = 32;
	localparam int CTX_W        = 64;
	localparam int COUNT_W      = 4;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 1;

	// bytes packed into one context field
	localparam int CTX_PACK = CTX_W / 8;

	// zero bytes below the oldest history byte, covers reads past the history
	localparam int HIST_PAD = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 1'b1;

	localparam logic [LENGTH_W-1:0] NEEDLE_LENGTH_RST = 4'd1;

endpackage

@@ hw/rtl/literal_byte_matcher_with_context_top.sv @@
// a match is compared in the cycle its last needle byte is accepted; once its after window
// fills it enters the emit stage, and its result then leaves through the output register
// throughput: one byte per cycle while the emit stage is free; the byte that ends a haystack
// flushes its pending matches one per cycle while the receiver is ready, set by the single emit unit
// reset (arst_n low, asynchronous): history, position and pending matches cleared,
// needle bytes zero, needle length one, no item held
module literal_byte_matcher_with_context_top #(
	parameter int MAX_NEEDLE    = lbm_pkg::MAX_NEEDLE_DEF,
	parameter int CONTEXT_BYTES = lbm_pkg::CONTEXT_BYTES_DEF,
	parameter int OFFSET_WIDTH  = lbm_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [lbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// haystack byte channel
	input  logic                              data_valid,
	output logic                              data_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              end_of_haystack,
	// result channel
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [lbm_pkg::OFFSET_OUT_W-1:0]  match_offset,
	output logic [lbm_pkg::CTX_W-1:0]         before_context,
	output logic [lbm_pkg::COUNT_W-1:0]       before_count,
	output logic [lbm_pkg::CTX_W-1:0]         after_context,
	output logic [lbm_pkg::COUNT_W-1:0]       after_count,
	output logic                              last_result
);
	import lbm_pkg::*;

	localparam int HIST_DEPTH = MAX_NEEDLE + 2 * CONTEXT_BYTES;
	localparam int PEND_W     = CONTEXT_BYTES + 1;
	localparam int CNT_W      = $clog2(CONTEXT_BYTES + 1);
	localparam int EXT_BYTES  = HIST_DEPTH + HIST_PAD;
	localparam int SH_W       = $clog2(EXT_BYTES + 1);
	localparam int POS_W      = OFFSET_WIDTH;

	// configuration
	logic [NEEDLE_W-1:0] needle_q;
	logic [LENGTH_W-1:0] length_q;
	logic [LENGTH_W-1:0] eff_len;

	// live scan state
	logic [7:0]        hist_q [HIST_DEPTH];
	logic [7:0]        hist_nx [HIST_DEPTH];
	logic [POS_W-1:0]  pos_q;
	logic [PEND_W-1:0] pend_q;
	logic [PEND_W-1:0] pend_nx;
	logic              hit;

	// emit stage: snapshot of the history and the matches still to report
	logic [7:0]        hist_s1 [HIST_DEPTH];
	logic [POS_W-1:0]  cur_s1;
	logic [PEND_W-1:0] mask_s1;
	logic [PEND_W-1:0] mask_rem;
	logic [PEND_W-1:0] pick_oh;
	logic [CNT_W-1:0]  pick_age;

	// output register
	logic                    valid_s2;
	logic [OFFSET_OUT_W-1:0] offset_s2;
	logic [CTX_W-1:0]        before_s2;
	logic [COUNT_W-1:0]      bcount_s2;
	logic [CTX_W-1:0]        after_s2;
	logic [COUNT_W-1:0]      acount_s2;
	logic                    last_s2;

	// emit datapath
	logic [POS_W:0]          cur_p1;
	logic [POS_W:0]          sub_e;
	logic [POS_W-1:0]        off_e;
	logic [63:0]             off_w;
	logic [CNT_W-1:0]        bc_e;
	logic [8*EXT_BYTES-1:0]  ext;
	logic [8*EXT_BYTES-1:0]  ext_b;
	logic [8*EXT_BYTES-1:0]  ext_a;
	logic [SH_W-1:0]         bshift;
	logic [SH_W-1:0]         ashift;
	logic [CTX_W-1:0]        before_e;
	logic [CTX_W-1:0]        after_e;

	logic accept;
	logic s2_free;
	logic emit_fire;
	logic s1_free;

	// needle length above MAX_NEEDLE is cut to the maximum
	always_comb begin
		if (int'(length_q) > MAX_NEEDLE) begin
			eff_len = LENGTH_W'(MAX_NEEDLE);
		end else begin
			eff_len = length_q;
		end
	end

	// history after the incoming byte is shifted in
	always_comb begin
		hist_nx[0] = data_byte;
		for (int j = 1; j < HIST_DEPTH; j++) begin
			hist_nx[j] = hist_q[j-1];
		end
	end

	// parallel compare of the newest bytes against the needle
	always_comb begin
		logic [POS_W:0]      pos_p1;
		logic [LENGTH_W-1:0] nk;
		logic [7:0]          nb;
		pos_p1 = {1'b0, pos_q} + (POS_W+1)'(1);
		nk     = '0;
		nb     = '0;
		hit    = (eff_len != '0) && (pos_p1 >= (POS_W+1)'(eff_len));
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			if (j < int'(eff_len)) begin
				// newest byte meets the last needle byte
				nk = eff_len - LENGTH_W'(j + 1);
				nb = 8'(needle_q >> {nk, 3'b000});
				if (hist_nx[j] != nb) begin
					hit = 1'b0;
				end
			end
		end
	end

	assign pend_nx = {pend_q[PEND_W-2:0], hit};

	// handshake
	assign s2_free    = !valid_s2 || result_ready;
	assign emit_fire  = (mask_s1 != '0) && s2_free;
	assign s1_free    = (mask_s1 == '0) || (emit_fire && (mask_rem == '0));
	assign data_ready = s1_free;
	assign accept     = data_valid && data_ready;

	// oldest pending match goes first
	always_comb begin
		pick_age = '0;
		pick_oh  = '0;
		for (int i = 0; i < PEND_W; i++) begin
			if (mask_s1[i]) begin
				pick_age = CNT_W'(i);
				pick_oh  = PEND_W'(1) << i;
			end
		end
	end

	assign mask_rem = mask_s1 & ~pick_oh;

	// offset of the match, clamped at zero
	always_comb begin
		cur_p1 = {1'b0, cur_s1} + (POS_W+1)'(1);
		sub_e  = (POS_W+1)'(pick_age) + (POS_W+1)'(eff_len);
		if (cur_p1 >= sub_e) begin
			off_e = POS_W'(cur_p1 - sub_e);
		end else begin
			off_e = '0;
		end
		if (off_e < POS_W'(CONTEXT_BYTES)) begin
			bc_e = CNT_W'(off_e);
		end else begin
			bc_e = CNT_W'(CONTEXT_BYTES);
		end
		off_w = 64'(off_e);
	end

	// history oldest first above a zero pad, so a shift picks any window
	always_comb begin
		ext = '0;
		for (int j = 0; j < HIST_DEPTH; j++) begin
			ext[8*(HIST_PAD+j) +: 8] = hist_s1[HIST_DEPTH-1-j];
		end
	end

	assign bshift = SH_W'(EXT_BYTES) - SH_W'(pick_age) - SH_W'(eff_len) - SH_W'(bc_e);
	assign ashift = SH_W'(EXT_BYTES) - SH_W'(pick_age);
	assign ext_b  = ext >> {bshift, 3'b000};
	assign ext_a  = ext >> {ashift, 3'b000};

	always_comb begin
		before_e = '0;
		after_e  = '0;
		for (int k = 0; k < CTX_PACK; k++) begin
			if (k < int'(bc_e)) begin
				before_e[8*k +: 8] = ext_b[8*k +: 8];
			end
			if (k < int'(pick_age)) begin
				after_e[8*k +: 8] = ext_a[8*k +: 8];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q <= '0;
			length_q <= NEEDLE_LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NEEDLE_BYTES:  needle_q <= cfg_data[NEEDLE_W-1:0];
				REG_NEEDLE_LENGTH: length_q <= cfg_data[LENGTH_W-1:0];
				default:           ;
			endcase
		end
	end

	// scan state, cleared after the final byte of a haystack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= '0;
			for (int j = 0; j < HIST_DEPTH; j++) begin
				hist_q[j] <= '0;
			end
		end else if (accept) begin
			if (end_of_haystack) begin
				pos_q  <= '0;
				pend_q <= '0;
				for (int j = 0; j < HIST_DEPTH; j++) begin
					hist_q[j] <= '0;
				end
			end else begin
				// full after window leaves the pending set
				pend_q <= {1'b0, pend_nx[PEND_W-2:0]};
				if (pos_q != '1) begin
					pos_q <= pos_q + POS_W'(1);
				end
				for (int j = 0; j < HIST_DEPTH; j++) begin
					hist_q[j] <= hist_nx[j];
				end
			end
		end
	end

	// emit stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (accept) begin
			if (end_of_haystack) begin
				mask_s1 <= pend_nx;
			end else begin
				mask_s1 <= {pend_nx[PEND_W-1], (PEND_W-1)'(0)};
			end
		end else if (emit_fire) begin
			mask_s1 <= mask_rem;
		end
	end

	// emit stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= pos_q;
			for (int j = 0; j < HIST_DEPTH; j++) begin
				hist_s1[j] <= hist_nx[j];
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (emit_fire) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			offset_s2 <= off_w[OFFSET_OUT_W-1:0];
			before_s2 <= before_e;
			bcount_s2 <= COUNT_W'(bc_e);
			after_s2  <= after_e;
			acount_s2 <= COUNT_W'(pick_age);
			last_s2   <= (mask_rem == '0);
		end
	end

	assign result_valid   = valid_s2;
	assign match_offset   = offset_s2;
	assign before_context = before_s2;
	assign before_count   = bcount_s2;
	assign after_context  = after_s2;
	assign after_count    = acount_s2;
	assign last_result    = last_s2;

endmodule

@@ dv/match_report_checker.sv @@
`timescale 1ns / 100ps

module match_report_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             data_valid,
	input  logic                             data_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             end_of_haystack,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  logic [lbm_pkg::OFFSET_OUT_W-1:0] match_offset,
	input  logic [lbm_pkg::CTX_W-1:0]        before_context,
	input  logic [lbm_pkg::COUNT_W-1:0]      before_count,
	input  logic [lbm_pkg::CTX_W-1:0]        after_context,
	input  logic [lbm_pkg::COUNT_W-1:0]      after_count,
	input  logic                             last_result,
	output int                               mismatch_count,
	output int                               reports_awaited
);

	localparam int CTX        = lbm_pkg::CONTEXT_BYTES_DEF;
	localparam int NEEDLE_MAX = lbm_pkg::MAX_NEEDLE_DEF;
	localparam int HIST_LEN   = NEEDLE_MAX + 2 * CTX;
	localparam logic [lbm_pkg::OFFSET_WIDTH_DEF-1:0] POSITION_TOP = '1;

	typedef struct packed {
		logic [lbm_pkg::OFFSET_OUT_W-1:0] offset;
		logic [lbm_pkg::CTX_W-1:0]        prior;
		logic [lbm_pkg::COUNT_W-1:0]      bcount;
		logic [lbm_pkg::CTX_W-1:0]        after;
		logic [lbm_pkg::COUNT_W-1:0]      acount;
		logic                             last;
	} match_report_t;

	logic [lbm_pkg::NEEDLE_W-1:0]         needle;
	logic [lbm_pkg::LENGTH_W-1:0]         needle_len;
	logic [HIST_LEN*8-1:0]                history;
	logic [lbm_pkg::OFFSET_WIDTH_DEF-1:0] position;
	logic [CTX:0]                         pending_hits;
	match_report_t                        expected_reports [$];

	function automatic int unsigned active_length();
		if (needle_len > NEEDLE_MAX)
			return NEEDLE_MAX;
		return needle_len;
	endfunction

	function automatic logic [7:0] history_byte(longint unsigned d);
		if (d < HIST_LEN)
			return history[8*int'(d) +: 8];
		return 8'h00;
	endfunction

	// match whose last needle byte came age bytes ago, cur is the current byte index
	function automatic match_report_t describe_match(longint unsigned cur, int unsigned age,
			int unsigned after_len, logic is_last);
		match_report_t r;
		longint unsigned len, off, bc;
		int k;
		r = '0;
		len = active_length();
		off = 0;
		if (cur >= age && cur - age + 1 >= len)
			off = cur - age + 1 - len;
		bc = (off < CTX) ? off : CTX;
		for (k = 0; k < bc; k++)
			r.prior[8*k +: 8] = history_byte(age + len + bc - k - 1);
		for (k = 0; k < after_len; k++)
			r.after[8*k +: 8] = history_byte(age - k - 1);
		r.offset = off[lbm_pkg::OFFSET_OUT_W-1:0];
		r.bcount = bc[lbm_pkg::COUNT_W-1:0];
		r.acount = after_len[lbm_pkg::COUNT_W-1:0];
		r.last   = is_last;
		return r;
	endfunction

	task automatic absorb_byte(logic [7:0] b, logic closing);
		longint unsigned cur;
		int unsigned len;
		logic hit;
		logic [CTX:0] younger;
		int k, a;
		cur = position;
		len = active_length();
		history = {history[HIST_LEN*8-9:0], b};
		pending_hits = pending_hits << 1;
		if (len > 0 && cur + 1 >= len) begin
			hit = 1'b1;
			for (k = 0; k < len; k++)
				if (history[8*(len-1-k) +: 8] != needle[8*k +: 8])
					hit = 1'b0;
			if (hit)
				pending_hits[0] = 1'b1;
		end
		if (closing) begin
			// oldest first, shortened after windows
			for (a = CTX; a >= 0; a--) begin
				if (pending_hits[a]) begin
					younger = pending_hits << (CTX + 1 - a);
					expected_reports = {expected_reports,
						describe_match(cur, a, a, younger == '0)};
				end
			end
			history = '0;
			position = '0;
			pending_hits = '0;
		end else begin
			if (pending_hits[CTX]) begin
				expected_reports = {expected_reports, describe_match(cur, CTX, CTX, 1'b1)};
				pending_hits[CTX] = 1'b0;
			end
			if (position != POSITION_TOP)
				position = position + 1;
		end
	endtask

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [63:0] seen, logic [63:0] wanted);
		if (seen !== wanted)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, wanted));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		match_report_t want;
		if (!arst_n) begin
			needle = '0;
			needle_len = lbm_pkg::NEEDLE_LENGTH_RST;
			history = '0;
			position = '0;
			pending_hits = '0;
			expected_reports.delete();
			mismatch_count = 0;
			reports_awaited = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_reports.pop_front();
					check_field("match_offset", match_offset, want.offset);
					check_field("before_context", before_context, want.prior);
					check_field("before_count", before_count, want.bcount);
					check_field("after_context", after_context, want.after);
					check_field("after_count", after_count, want.acount);
					check_field("last_result", last_result, want.last);
				end
			end
			if (cfg_write) begin
				if (cfg_index == lbm_pkg::REG_NEEDLE_BYTES)
					needle = cfg_data;
				else if (cfg_index == lbm_pkg::REG_NEEDLE_LENGTH)
					needle_len = cfg_data[lbm_pkg::LENGTH_W-1:0];
			end
			if (data_valid && data_ready)
				absorb_byte(data_byte, end_of_haystack);
			reports_awaited = expected_reports.size();
		end
	end

endmodule

@@ dv/literal_byte_matcher_with_context_top_test.sv @@
`timescale 1ns / 100ps

module literal_byte_matcher_with_context_top_test;

	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 22;
	localparam int STEADY_PHASE   = 3;	// nobody idles here
	localparam int PRESSURE_PHASE = 6;	// receiver holds off, every byte matches
	localparam int HOLD_CYCLES    = 80;
	// comparison, output register and a full flush burst, with margin
	localparam int SETTLE_CYCLES  = 24;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [lbm_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                             data_valid = 1'b0;
	logic                             data_ready;
	logic [7:0]                       data_byte = '0;
	logic                             end_of_haystack = 1'b0;
	logic                             result_valid;
	logic                             result_ready = 1'b0;
	logic [lbm_pkg::OFFSET_OUT_W-1:0] match_offset;
	logic [lbm_pkg::CTX_W-1:0]        before_context;
	logic [lbm_pkg::COUNT_W-1:0]      before_count;
	logic [lbm_pkg::CTX_W-1:0]        after_context;
	logic [lbm_pkg::COUNT_W-1:0]      after_count;
	logic                             last_result;

	int mismatch_count;
	int reports_awaited;

	// shared between the stimulus and the receiver
	bit steady = 1'b0;
	int holds_asked = 0;
	int holds_done = 0;

	// haystack bookkeeping for the random part
	int hay_left;
	int items_sent;
	int phase_lengths [PHASES];

	literal_byte_matcher_with_context_top DUT (.*);

	match_report_checker u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// generous ceiling, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("literal_byte_matcher_with_context_top_test failed");
		$finish;
	end

	// roughly 18 idle cycles in a hundred, none in the steady phase
	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 18);
	endfunction

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end else begin
				result_ready <= !idle_now();
			end
		end
	end

	// all tasks below start and end on a falling edge
	task automatic write_register(logic [lbm_pkg::CFG_IDX_W-1:0] idx,
			logic [lbm_pkg::CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// valid stays high after acceptance so back-to-back items need no gap
	task automatic send_byte(logic [7:0] b, logic closing);
		while (idle_now()) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid      <= 1'b1;
		data_byte       <= b;
		end_of_haystack <= closing;
		do
			@(posedge clk);
		while (!data_ready);
		@(negedge clk);
	endtask

	// drop valid, let every expected result out, then give the block time to go quiet
	task automatic settle();
		data_valid <= 1'b0;
		while (reports_awaited != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic feed_haystack(logic [7:0] b);
		hay_left--;
		send_byte(b, hay_left == 0);
		if (hay_left == 0)
			hay_left = $urandom_range(1, 30);
		items_sent++;
	endtask

	// random needle, often with repeated bytes so that matches overlap
	function automatic logic [63:0] pick_needle();
		logic [63:0] n;
		int k;
		n = {$urandom, $urandom};
		if ($urandom_range(1))
			for (k = 1; k < 8; k++)
				if ($urandom_range(1))
					n[8*k +: 8] = n[7:0];
		return n;
	endfunction

	initial begin
		logic [63:0] needle;
		int phase, len, used, roll, piece, k, i;

		phase_lengths = '{1, 8, 3, 2, 0, 15, 1, 8, 5, 4};

		// reset held low at the start, released on a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full-length needle of all ones, overlapping hits flushed at the end
		write_register(lbm_pkg::REG_NEEDLE_BYTES, '1);
		write_register(lbm_pkg::REG_NEEDLE_LENGTH, 64'd8);
		for (i = 0; i < 9; i++)
			send_byte(8'hFF, i == 8);
		settle();

		// zero length: nothing can match
		write_register(lbm_pkg::REG_NEEDLE_LENGTH, 64'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b1);
		settle();

		// length above the maximum reads as eight, all-zero needle
		write_register(lbm_pkg::REG_NEEDLE_BYTES, '0);
		write_register(lbm_pkg::REG_NEEDLE_LENGTH, 64'd15);
		for (i = 0; i < 8; i++)
			send_byte(8'h00, 1'b0);
		settle();
		// shorten the needle while that hit is still waiting for its after window
		write_register(lbm_pkg::REG_NEEDLE_LENGTH, 64'd1);
		send_byte(8'hAA, 1'b1);
		settle();

		// lengthen it under a pending hit at position zero: offset would go negative
		send_byte(8'h00, 1'b0);
		settle();
		write_register(lbm_pkg::REG_NEEDLE_LENGTH, 64'd8);
		send_byte(8'h00, 1'b1);
		settle();

		// random phases: mostly needle copies and needle bytes, some broken copies
		// and noise; a phase may end mid-haystack so the next one reconfigures
		// with hits still pending
		hay_left = $urandom_range(1, 30);
		for (phase = 0; phase < PHASES; phase++) begin
			len = phase_lengths[phase];
			used = (len > 8) ? 8 : len;
			needle = pick_needle();
			write_register(lbm_pkg::REG_NEEDLE_BYTES, needle);
			write_register(lbm_pkg::REG_NEEDLE_LENGTH, 64'(len));
			steady = (phase == STEADY_PHASE);
			if (phase == PRESSURE_PHASE)
				holds_asked++;
			for (items_sent = 0; items_sent < PHASE_ITEMS; ) begin
				roll = (phase == PRESSURE_PHASE) ? 0 : $urandom_range(99);
				if (roll < 50) begin
					// whole copy, or a prefix of one that breaks off
					piece = (roll < 35) ? used : $urandom_range(used);
					for (k = 0; k < piece; k++)
						feed_haystack(needle[8*k +: 8]);
				end else if (roll < 80) begin
					k = $urandom_range(7);
					feed_haystack(needle[8*k +: 8]);
				end else begin
					feed_haystack(8'($urandom_range(255)));
				end
			end
			settle();
		end
		steady = 1'b0;

		if (mismatch_count == 0)
			$display("literal_byte_matcher_with_context_top_test passed");
		else
			$display("literal_byte_matcher_with_context_top_test failed");
		$finish;
	end

endmodule
